FILE: design/sha256_pkg.sv
// Shared constants and round functions of the SHA-256 digest core.
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned ChainWords = 8;
  localparam int unsigned Rounds     = 64;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Round constants, one per compression round
  localparam logic [31:0] ROUND_K [0:Rounds-1] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Initial chaining values
  localparam logic [31:0] INIT_HASH [0:ChainWords-1] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

FILE: design/sha256_message_digest.sv
// SHA-256 over a byte stream: byte packing, padding, iterative compression, digest output.
//
//   channel   direction  handshake                    payload
//   byte      in         byte_valid / byte_ready      data_byte, has_byte, end_of_message
//   digest    out        digest_valid / digest_ready  digest_word, word_index, last_word
//
// A byte that does not complete a 64-byte block is only packed; a completing byte starts
// compression: 64 rounds of the single round unit, then one chaining add.
// An end-of-message transaction adds a padding step and one compression per padding block,
// with a setup step (S_LEN) for a second block, then eight digest transactions.
// Synchronous reset restores the initial chaining values and a zero byte count.
// Byte input stalls during padding, compression and while the digest drains; low digest_ready holds.
`timescale 1ns / 1ps
`default_nettype none

module sha256_message_digest (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        end_of_message,
  output logic             digest_valid,
  input  wire logic        digest_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_PAD,
    S_LEN,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    NEXT_IDLE,
    NEXT_PAD,
    NEXT_LEN,
    NEXT_OUT
  } after_t;

  state_t      state;
  after_t      after;
  logic [5:0]  round;
  logic [2:0]  out_idx;
  logic [60:0] byte_count;
  logic [31:0] chain_words   [0:sha256_pkg::ChainWords-1];
  logic [31:0] working_words [0:sha256_pkg::ChainWords-1];
  logic [31:0] block_words   [0:sha256_pkg::BlockWords-1];

  logic        byte_take;
  logic [5:0]  pos;
  logic [3:0]  widx;
  logic [4:0]  bshift;
  logic [63:0] bit_len;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] sched_next;

  assign byte_ready   = (state == S_IDLE);
  assign digest_valid = (state == S_OUT);
  assign digest_word  = chain_words[out_idx];
  assign word_index   = out_idx;
  assign last_word    = (out_idx == 3'd7);

  assign byte_take = byte_valid && byte_ready;
  assign pos       = byte_count[5:0];
  assign widx      = pos[5:2];
  assign bshift    = {~pos[1:0], 3'b000};
  assign bit_len   = {byte_count, 3'b000};

  // Round unit and message schedule extension
  always_comb begin
    t1 = working_words[7] + sha256_pkg::big_sigma1(working_words[4])
       + ((working_words[4] & working_words[5]) ^ (~working_words[4] & working_words[6]))
       + sha256_pkg::ROUND_K[round] + block_words[0];
    t2 = sha256_pkg::big_sigma0(working_words[0])
       + ((working_words[0] & working_words[1]) ^ (working_words[0] & working_words[2])
          ^ (working_words[1] & working_words[2]));
    sched_next = sha256_pkg::small_sigma1(block_words[14]) + block_words[9]
               + sha256_pkg::small_sigma0(block_words[1]) + block_words[0];
  end

  // Sequencer, chaining state and block buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      after      <= NEXT_IDLE;
      round      <= '0;
      out_idx    <= '0;
      byte_count <= '0;
      for (int i = 0; i < sha256_pkg::ChainWords; i++) begin
        chain_words[i] <= sha256_pkg::INIT_HASH[i];
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (byte_take) begin
            if (has_byte) begin
              // Pack byte big-endian; first byte of a word clears it
              if (pos[1:0] == 2'b00) begin
                block_words[widx] <= {24'b0, data_byte} << bshift;
              end else begin
                block_words[widx] <= block_words[widx] | ({24'b0, data_byte} << bshift);
              end
              byte_count <= byte_count + 61'd1;
            end
            if (has_byte && (pos == 6'd63)) begin
              working_words <= chain_words;
              round         <= '0;
              after         <= end_of_message ? NEXT_PAD : NEXT_IDLE;
              state         <= S_ROUND;
            end else if (end_of_message) begin
              state <= S_PAD;
            end
          end
        end

        S_PAD: begin
          // Place the pad byte, clear the rest of the block and add the bit length if it fits
          for (int i = 0; i < sha256_pkg::BlockWords; i++) begin
            if (4'(i) > widx) begin
              block_words[i] <= '0;
            end
          end
          if (pos[1:0] == 2'b00) begin
            block_words[widx] <= {24'b0, sha256_pkg::PAD_BYTE} << bshift;
          end else begin
            block_words[widx] <= block_words[widx]
                               | ({24'b0, sha256_pkg::PAD_BYTE} << bshift);
          end
          if (pos[5:3] == 3'b111) begin
            after <= NEXT_LEN;
          end else begin
            block_words[14] <= bit_len[63:32];
            block_words[15] <= bit_len[31:0];
            after           <= NEXT_OUT;
          end
          working_words <= chain_words;
          round         <= '0;
          state         <= S_ROUND;
        end

        S_LEN: begin
          // Extra block holding only zeros and the bit length
          for (int i = 0; i < sha256_pkg::BlockWords - 2; i++) begin
            block_words[i] <= '0;
          end
          block_words[14] <= bit_len[63:32];
          block_words[15] <= bit_len[31:0];
          working_words   <= chain_words;
          round           <= '0;
          after           <= NEXT_OUT;
          state           <= S_ROUND;
        end

        S_ROUND: begin
          // One round per cycle; the schedule window shifts down by one word
          working_words[7] <= working_words[6];
          working_words[6] <= working_words[5];
          working_words[5] <= working_words[4];
          working_words[4] <= working_words[3] + t1;
          working_words[3] <= working_words[2];
          working_words[2] <= working_words[1];
          working_words[1] <= working_words[0];
          working_words[0] <= t1 + t2;
          for (int i = 0; i < sha256_pkg::BlockWords - 1; i++) begin
            block_words[i] <= block_words[i + 1];
          end
          block_words[sha256_pkg::BlockWords-1] <= sched_next;
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= S_ADD;
          end
        end

        S_ADD: begin
          for (int i = 0; i < sha256_pkg::ChainWords; i++) begin
            chain_words[i] <= chain_words[i] + working_words[i];
          end
          unique case (after)
            NEXT_IDLE: state <= S_IDLE;
            NEXT_PAD:  state <= S_PAD;
            NEXT_LEN:  state <= S_LEN;
            NEXT_OUT: begin
              out_idx <= '0;
              state   <= S_OUT;
            end
            default:   state <= S_IDLE;
          endcase
        end

        S_OUT: begin
          // Drain the digest; the last transaction reopens a new message
          if (digest_ready) begin
            if (out_idx == 3'd7) begin
              for (int i = 0; i < sha256_pkg::ChainWords; i++) begin
                chain_words[i] <= sha256_pkg::INIT_HASH[i];
              end
              byte_count <= '0;
              out_idx    <= '0;
              state      <= S_IDLE;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
